// ===== rtl/dheap_pkg.sv =====
package dheap_pkg;

  localparam int CAPACITY  = 1024;
  localparam int MAX_ARITY = 8;

  localparam int DATA_W  = 32;
  localparam int CFG_W   = 4;
  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int ARITY_W = $clog2(MAX_ARITY + 1);
  localparam int CHILD_W = IDX_W + ARITY_W;

  // Parent index by multiplication with a rounded-up reciprocal of the arity.
  // With the shift at IDX_W plus the bits of the largest arity the quotient is
  // exact for every index below 2**IDX_W.
  localparam int PAR_SH = IDX_W + $clog2(MAX_ARITY);
  localparam int RCP_W  = PAR_SH;
  localparam int PROD_W = IDX_W + RCP_W;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DELETE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_WR,
    S_UP_PAR,
    S_FAM_P,
    S_FAM_S,
    S_SWAP_A,
    S_SWAP_B,
    S_ROOT_RD,
    S_RESULT
  } state_e;

  typedef logic [RCP_W-1:0] rcp_arr_t [MAX_ARITY+1];

  localparam logic [RCP_W-1:0] RCP_2 = RCP_W'(((1 << PAR_SH) + 1) / 2);
  localparam logic [RCP_W-1:0] RCP_3 = RCP_W'(((1 << PAR_SH) + 2) / 3);
  localparam logic [RCP_W-1:0] RCP_4 = RCP_W'(((1 << PAR_SH) + 3) / 4);
  localparam logic [RCP_W-1:0] RCP_5 = RCP_W'(((1 << PAR_SH) + 4) / 5);
  localparam logic [RCP_W-1:0] RCP_6 = RCP_W'(((1 << PAR_SH) + 5) / 6);
  localparam logic [RCP_W-1:0] RCP_7 = RCP_W'(((1 << PAR_SH) + 6) / 7);
  localparam logic [RCP_W-1:0] RCP_8 = RCP_W'(((1 << PAR_SH) + 7) / 8);

  // Arities below two never reach the table, so their entries are zero.
  localparam rcp_arr_t RCP_TAB = '{'0, '0, RCP_2, RCP_3, RCP_4, RCP_5, RCP_6, RCP_7, RCP_8};

endpackage

// ===== rtl/dheap_idx.sv =====
module dheap_idx
  import dheap_pkg::*;
(
  input  logic [IDX_W-1:0]   idx_i,
  input  logic [IDX_W-1:0]   node_i,
  input  logic [ARITY_W-1:0] arity_i,
  output logic [IDX_W-1:0]   parent_o,
  output logic [CHILD_W-1:0] first_child_o
);

  logic [PROD_W-1:0] prod;

  // Parent of a non-root index: (idx - 1) / arity, done as a reciprocal multiply.
  assign prod = PROD_W'(idx_i - 1'b1) * PROD_W'(RCP_TAB[arity_i]);
  assign parent_o = prod[PAR_SH +: IDX_W];

  assign first_child_o = CHILD_W'(node_i) * CHILD_W'(arity_i) + CHILD_W'(1);

endmodule

// ===== rtl/d_ary_min_heap_top.sv =====
// Min-heap priority queue of signed 32-bit values with a configurable arity.
// Command channel: an item (mode_i, value_i) is taken at a rising edge with
// start high and busy low. Mode insert adds value_i; mode delete removes the
// minimum. busy stays high while the item is worked on.
// Result channel: done_o is high for exactly one cycle with min_value_o,
// element_count_o, heap_empty_o and status_o. The receiver cannot stall it;
// a new item may be started in the same cycle that done_o is high.
// Configuration: cfg_data_i is written to the arity register when cfg_valid_i
// is high; cfg_ready_o is always high. Arity below 2 acts as 2 and above 8
// acts as 8. Write it only while the block is idle.
// Operation: every heap level costs one pass of a single shared compare unit over
// the parent and its children through the one read port of the heap memory,
// then, where a child is smaller, two writes for the swap (S_SWAP_A, S_SWAP_B).
// A refused item does not touch the heap and goes straight to the result.
// Reset clears the count and sets the arity to 2; the memory is not cleared,
// as entries beyond the count are never used.
module d_ary_min_heap_top
  import dheap_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     mode_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     done_o,
  output logic signed [DATA_W-1:0] min_value_o,
  output logic [CNT_W-1:0]         element_count_o,
  output logic                     heap_empty_o,
  output logic [1:0]               status_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_W-1:0]         cfg_data_i
);

  state_e state_q, state_d;

  logic [CFG_W-1:0]   arity_q;
  logic [ARITY_W-1:0] eff_arity;
  logic [ARITY_W-1:0] d_q, d_d;
  logic               mode_q, mode_d;
  logic signed [DATA_W-1:0] value_q, value_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  status_e            status_q, status_d;

  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [IDX_W-1:0]   node_q, node_d;
  logic [CHILD_W-1:0] child_q, child_d;
  logic [ARITY_W-1:0] left_q, left_d;
  logic [IDX_W-1:0]   best_idx_q, best_idx_d;
  logic signed [DATA_W-1:0] best_val_q, best_val_d;
  logic signed [DATA_W-1:0] par_val_q, par_val_d;
  logic               par_wait_q, par_wait_d;
  logic               chd_wait_q, chd_wait_d;
  logic [IDX_W-1:0]   chd_idx_q, chd_idx_d;

  logic               done_q, done_d;
  logic signed [DATA_W-1:0] out_min_q, out_min_d;
  logic [CNT_W-1:0]   out_cnt_q, out_cnt_d;
  logic               out_empty_q, out_empty_d;
  status_e            out_status_q, out_status_d;

  logic signed [DATA_W-1:0] mem [CAPACITY];
  logic signed [DATA_W-1:0] rd_data_q;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [IDX_W-1:0]   mem_raddr;
  logic signed [DATA_W-1:0] mem_wdata;

  logic [IDX_W-1:0]   parent;
  logic [CHILD_W-1:0] first_child;
  logic               issue;
  logic               less;
  logic               accept;

  dheap_idx u_idx (
    .idx_i         (idx_q),
    .node_i        (node_q),
    .arity_i       (d_q),
    .parent_o      (parent),
    .first_child_o (first_child)
  );

  assign busy        = (state_q != S_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (arity_q < CFG_W'(2)) begin
      eff_arity = ARITY_W'(2);
    end else if (int'(arity_q) > MAX_ARITY) begin
      eff_arity = ARITY_W'(MAX_ARITY);
    end else begin
      eff_arity = ARITY_W'(arity_q);
    end
  end

  // Another child is fetched while the family has children left inside the heap.
  assign issue = (left_q != '0) && (child_q < CHILD_W'(cnt_q));
  // The one compare unit: strictly smaller only, so ties keep the lower index.
  assign less  = rd_data_q < best_val_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (mode_i)
            MODE_INSERT: state_d = (cnt_q == CNT_W'(CAPACITY)) ? S_ROOT_RD : S_INS_WR;
            MODE_DELETE: state_d = (cnt_q == '0) ? S_ROOT_RD : S_DEL_RD;
            default:     state_d = S_IDLE;
          endcase
        end
      end
      S_INS_WR:  state_d = (cnt_q == '0) ? S_ROOT_RD : S_UP_PAR;
      S_UP_PAR:  state_d = S_FAM_P;
      S_FAM_P:   state_d = S_FAM_S;
      S_FAM_S:   state_d = issue ? S_FAM_S : S_SWAP_A;
      S_SWAP_A:  state_d = (best_idx_q == node_q) ? S_ROOT_RD : S_SWAP_B;
      S_SWAP_B: begin
        if (mode_q == MODE_INSERT) begin
          state_d = (node_q == '0) ? S_ROOT_RD : S_UP_PAR;
        end else begin
          state_d = S_FAM_P;
        end
      end
      S_DEL_RD:  state_d = S_DEL_WR;
      S_DEL_WR:  state_d = S_FAM_P;
      S_ROOT_RD: state_d = S_RESULT;
      S_RESULT:  state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    d_d          = d_q;
    mode_d       = mode_q;
    value_d      = value_q;
    cnt_d        = cnt_q;
    status_d     = status_q;
    idx_d        = idx_q;
    node_d       = node_q;
    child_d      = child_q;
    left_d       = left_q;
    best_idx_d   = best_idx_q;
    best_val_d   = best_val_q;
    par_val_d    = par_val_q;
    par_wait_d   = 1'b0;
    chd_wait_d   = 1'b0;
    chd_idx_d    = chd_idx_q;
    done_d       = 1'b0;
    out_min_d    = out_min_q;
    out_cnt_d    = out_cnt_q;
    out_empty_d  = out_empty_q;
    out_status_d = out_status_q;
    mem_we       = 1'b0;
    mem_waddr    = node_q;
    mem_wdata    = best_val_q;
    mem_raddr    = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          mode_d   = mode_i;
          value_d  = value_i;
          d_d      = eff_arity;
          status_d = ST_DONE;
          case (mode_i)
            MODE_INSERT: if (cnt_q == CNT_W'(CAPACITY)) status_d = ST_FULL;
            MODE_DELETE: if (cnt_q == '0) status_d = ST_EMPTY;
            default:     status_d = ST_DONE;
          endcase
        end
      end
      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q[IDX_W-1:0];
        mem_wdata = value_q;
        idx_d     = cnt_q[IDX_W-1:0];
        cnt_d     = cnt_q + 1'b1;
      end
      S_UP_PAR: begin
        node_d = parent;
      end
      S_FAM_P: begin
        mem_raddr  = node_q;
        par_wait_d = 1'b1;
        child_d    = first_child;
        left_d     = d_q;
      end
      S_FAM_S: begin
        if (par_wait_q) begin
          best_val_d = rd_data_q;
          par_val_d  = rd_data_q;
          best_idx_d = node_q;
        end else if (chd_wait_q && less) begin
          best_val_d = rd_data_q;
          best_idx_d = chd_idx_q;
        end
        if (issue) begin
          mem_raddr  = child_q[IDX_W-1:0];
          chd_wait_d = 1'b1;
          chd_idx_d  = child_q[IDX_W-1:0];
          child_d    = child_q + 1'b1;
          left_d     = left_q - 1'b1;
        end
      end
      S_SWAP_A: begin
        if (best_idx_q != node_q) begin
          mem_we    = 1'b1;
          mem_waddr = node_q;
          mem_wdata = best_val_q;
        end
      end
      S_SWAP_B: begin
        mem_we    = 1'b1;
        mem_waddr = best_idx_q;
        mem_wdata = par_val_q;
        // Sift-up carries on at the parent, sift-down at the child swapped into.
        idx_d     = node_q;
        node_d    = best_idx_q;
      end
      S_DEL_RD: begin
        mem_raddr = IDX_W'(cnt_q - 1'b1);
        cnt_d     = cnt_q - 1'b1;
      end
      S_DEL_WR: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = rd_data_q;
        node_d    = '0;
      end
      S_ROOT_RD: begin
        mem_raddr = '0;
      end
      S_RESULT: begin
        done_d       = 1'b1;
        out_min_d    = (cnt_q == '0) ? '0 : rd_data_q;
        out_cnt_d    = cnt_q;
        out_empty_d  = (cnt_q == '0);
        out_status_d = status_q;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      arity_q    <= CFG_W'(2);
      cnt_q      <= '0;
      par_wait_q <= 1'b0;
      chd_wait_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      par_wait_q <= par_wait_d;
      chd_wait_q <= chd_wait_d;
      done_q     <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        arity_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    d_q          <= d_d;
    mode_q       <= mode_d;
    value_q      <= value_d;
    status_q     <= status_d;
    idx_q        <= idx_d;
    node_q       <= node_d;
    child_q      <= child_d;
    left_q       <= left_d;
    best_idx_q   <= best_idx_d;
    best_val_q   <= best_val_d;
    par_val_q    <= par_val_d;
    chd_idx_q    <= chd_idx_d;
    out_min_q    <= out_min_d;
    out_cnt_q    <= out_cnt_d;
    out_empty_q  <= out_empty_d;
    out_status_q <= out_status_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem[mem_raddr];
  end

  assign done_o          = done_q;
  assign min_value_o     = out_min_q;
  assign element_count_o = out_cnt_q;
  assign heap_empty_o    = out_empty_q;
  assign status_o        = out_status_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("Heap count exceeds capacity.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWAP_A && best_idx_q != node_q) |-> (CNT_W'(best_idx_q) < cnt_q))
    else $error("Chosen child lies outside the heap.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && out_status_q == ST_FULL) |-> (out_cnt_q == CNT_W'(CAPACITY)))
    else $error("Insert refused although the heap is not full.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && out_status_q == ST_EMPTY) |-> (out_empty_q && out_cnt_q == '0))
    else $error("Delete refused although the heap holds items.");
`endif

endmodule
